// ----- rtl/core/fmwv_pkg.sv -----
// Package for the two-operator FM wavetable voice.
// Holds the fixed table count, field widths, note decode and the period,
// conversion and reciprocal tables. No dependencies.
`timescale 1ns / 1ps

package fmwv_pkg;

    // Fixed geometry and default parameter values
    localparam int NUM_TABLES  = 12;
    localparam int TABLE_DEPTH = 512;
    localparam int SAMPLE_BITS = 16;

    // Field widths
    localparam int TBL_W  = 4;
    localparam int IDX_W  = 9;
    localparam int OCT_W  = 3;
    localparam int NOTE_W = 6;
    localparam int CONV_W = 23;
    localparam int RCP_W  = 17;

    // Reciprocals below are floor(2^RCP_SHIFT / period)
    localparam int RCP_SHIFT = 24;

    typedef struct packed {
        logic [TBL_W-1:0] tbl;
        logic [OCT_W-1:0] oct;
    } t_note;

    // Split a note code into semitone table and octave multiplier
    function automatic t_note note_decode(input logic [NOTE_W-1:0] code);
        t_note d;
        if (code < 6'd12) begin
            d.oct = 3'd1;
            d.tbl = 4'(code);
        end else if (code < 6'd24) begin
            d.oct = 3'd2;
            d.tbl = 4'(code - 6'd12);
        end else if (code < 6'd36) begin
            d.oct = 3'd3;
            d.tbl = 4'(code - 6'd24);
        end else if (code < 6'd48) begin
            d.oct = 3'd4;
            d.tbl = 4'(code - 6'd36);
        end else if (code < 6'd60) begin
            d.oct = 3'd5;
            d.tbl = 4'(code - 6'd48);
        end else begin
            d.oct = 3'd6;
            d.tbl = 4'(code - 6'd60);
        end
        return d;
    endfunction

    // Single-cycle table length per semitone
    function automatic logic [IDX_W-1:0] period_len(input logic [TBL_W-1:0] tbl);
        logic [IDX_W-1:0] len;
        unique case (tbl)
            4'd0:    len = 9'd437;
            4'd1:    len = 9'd412;
            4'd2:    len = 9'd389;
            4'd3:    len = 9'd367;
            4'd4:    len = 9'd347;
            4'd5:    len = 9'd327;
            4'd6:    len = 9'd309;
            4'd7:    len = 9'd292;
            4'd8:    len = 9'd275;
            4'd9:    len = 9'd260;
            4'd10:   len = 9'd245;
            4'd11:   len = 9'd232;
            default: len = 9'd232;
        endcase
        return len;
    endfunction

    // Phase-to-index conversion, unsigned Q7.16
    function automatic logic [CONV_W-1:0] conv_rom(input logic [TBL_W-1:0] tbl);
        logic [CONV_W-1:0] c;
        unique case (tbl)
            4'd0:    c = 23'd4551438;
            4'd1:    c = 23'd4296020;
            4'd2:    c = 23'd4054871;
            4'd3:    c = 23'd3827024;
            4'd4:    c = 23'd3612513;
            4'd5:    c = 23'd3409725;
            4'd6:    c = 23'd3218352;
            4'd7:    c = 23'd3037720;
            4'd8:    c = 23'd2867226;
            4'd9:    c = 23'd2706301;
            4'd10:   c = 23'd2554408;
            4'd11:   c = 23'd2411041;
            default: c = 23'd2411041;
        endcase
        return c;
    endfunction

    // Reciprocal of the table length for the modulo reduction
    function automatic logic [RCP_W-1:0] recip(input logic [TBL_W-1:0] tbl);
        logic [RCP_W-1:0] r;
        unique case (tbl)
            4'd0:    r = 17'd38391;
            4'd1:    r = 17'd40721;
            4'd2:    r = 17'd43129;
            4'd3:    r = 17'd45714;
            4'd4:    r = 17'd48349;
            4'd5:    r = 17'd51306;
            4'd6:    r = 17'd54295;
            4'd7:    r = 17'd57456;
            4'd8:    r = 17'd61008;
            4'd9:    r = 17'd64527;
            4'd10:   r = 17'd68478;
            4'd11:   r = 17'd72315;
            default: r = 17'd72315;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/fmwv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the wavetable sample memory.
`timescale 1ns / 1ps

module fmwv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 6144
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/fm_wavetable_synth_voice_unit.sv -----
// Top level of the two-operator FM wavetable voice: stream ports, config
// registers, sequencer and one shared 27x18 multiplier.
// Depends on fmwv_pkg and fmwv_ram.
`timescale 1ns / 1ps

//  channel   | direction | word contents (low bit first)
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | tuser: cmd; tdata: load_table, load_index, load_value
//  m_axis    | out       | tdata: sample
//  i_cfg_*   | in        | index 0..4: modulator_note, carrier_note,
//            |           | modulator_phase, carrier_phase, mod_depth
//
//  A wavetable load word is accepted while idle and writes the memory at once;
//  loads can follow back to back. A sample tick runs through the sequencer
//  states in turn, set by the chain of products through the one shared multiplier
//  and the two memory reads. Reset is synchronous; the wavetables hold
//  garbage until loaded. A tick whose sample cannot leave because the output
//  word is still waiting holds in its last step until the output frees up.

module fm_wavetable_synth_voice_unit #(
    parameter int TABLE_DEPTH = fmwv_pkg::TABLE_DEPTH,
    parameter int SAMPLE_BITS = fmwv_pkg::SAMPLE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port
    input  logic                                  i_cfg_wr_en,
    input  logic [2:0]                            i_cfg_index,
    input  logic [15:0]                           i_cfg_data,
    // Input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [3:0] load_table, [12:4] load_index, [28:13] load_value, [31:29] zero
    input  logic [31:0]                           s_axis_tdata,
    // [0] cmd
    input  logic                                  s_axis_tuser,
    // Output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [SAMPLE_BITS-1:0] sample, zero fill above
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata
);

    localparam int OUT_W    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int MEM_DEPTH = fmwv_pkg::NUM_TABLES * TABLE_DEPTH;
    localparam int AW       = $clog2(MEM_DEPTH);
    localparam int SH_DN    = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
    localparam int SH_UP    = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;

    // Register indexes
    localparam logic [2:0] REG_MOD_NOTE  = 3'd0;
    localparam logic [2:0] REG_CAR_NOTE  = 3'd1;
    localparam logic [2:0] REG_MOD_PHASE = 3'd2;
    localparam logic [2:0] REG_CAR_PHASE = 3'd3;
    localparam logic [2:0] REG_DEPTH     = 3'd4;

    // Commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MKM  = 4'd1;   // conv_m * octave_m
    localparam logic [3:0] ST_MV   = 4'd2;   // * modulator_phase
    localparam logic [3:0] ST_MX   = 4'd3;   // ceil + position offset
    localparam logic [3:0] ST_RED1 = 4'd4;   // x * reciprocal
    localparam logic [3:0] ST_RED2 = 4'd5;   // quotient * length
    localparam logic [3:0] ST_RED3 = 4'd6;   // remainder and fix-up
    localparam logic [3:0] ST_RD   = 4'd7;   // memory read
    localparam logic [3:0] ST_RDW  = 4'd8;   // read data back
    localparam logic [3:0] ST_CA   = 4'd9;   // depth*ms + phase; conv_c*octave_c
    localparam logic [3:0] ST_CLO  = 4'd10;  // K * low half
    localparam logic [3:0] ST_CHI  = 4'd11;  // K * high half
    localparam logic [3:0] ST_CY   = 4'd12;  // combine halves
    localparam logic [3:0] ST_CX   = 4'd13;  // ceil + position offset

    // Payload fields
    logic [fmwv_pkg::TBL_W-1:0] in_tbl;
    logic [fmwv_pkg::IDX_W-1:0] in_idx;
    logic [15:0]                in_val;
    assign in_tbl = s_axis_tdata[3:0];
    assign in_idx = s_axis_tdata[12:4];
    assign in_val = s_axis_tdata[28:13];

    // Control registers
    logic [3:0]                     r_state, n_state;
    logic                           r_car;
    logic                           r_reload;
    logic [fmwv_pkg::IDX_W-1:0]     r_mpos, n_mpos;
    logic [fmwv_pkg::IDX_W-1:0]     r_cpos, n_cpos;
    logic                           r_out_valid;
    logic [fmwv_pkg::NOTE_W-1:0]    r_mnote;
    logic [fmwv_pkg::NOTE_W-1:0]    r_cnote;
    logic signed [15:0]             r_mph;
    logic signed [15:0]             r_cph;
    logic signed [15:0]             r_depth;

    // Datapath registers
    logic signed [44:0]             r_prod;
    logic signed [17:0]             r_x, n_x;
    logic [fmwv_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic [32:0]                    r_a;
    logic [26:0]                    r_k;
    logic [41:0]                    r_p;
    logic [43:0]                    r_y;
    logic [SAMPLE_BITS-1:0]         r_out;

    // Decoded notes and selected table for reduction and read
    fmwv_pkg::t_note                mnote, cnote;
    logic [fmwv_pkg::TBL_W-1:0]     sel_tbl;
    logic [fmwv_pkg::IDX_W-1:0]     sel_len;
    logic [fmwv_pkg::IDX_W-1:0]     mlen, clen;
    assign mnote   = fmwv_pkg::note_decode(r_mnote);
    assign cnote   = fmwv_pkg::note_decode(r_cnote);
    assign sel_tbl = r_car ? cnote.tbl : mnote.tbl;
    assign sel_len = fmwv_pkg::period_len(sel_tbl);
    assign mlen    = fmwv_pkg::period_len(mnote.tbl);
    assign clen    = fmwv_pkg::period_len(cnote.tbl);

    // Handshakes
    logic in_fire, out_fire, tick_fire, load_fire, out_load;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign tick_fire = in_fire && (s_axis_tuser == CMD_TICK);
    assign load_fire = in_fire && (s_axis_tuser == CMD_LOAD);
    assign out_fire  = m_axis_tvalid && m_axis_tready;
    assign out_load  = (r_state == ST_RDW) && r_car && (!r_out_valid || m_axis_tready);

    // Wavetable memory
    logic                   mem_wr_en;
    logic [AW-1:0]          mem_wr_addr;
    logic [SAMPLE_BITS-1:0] mem_wr_data;
    logic                   mem_rd_en;
    logic [AW-1:0]          mem_rd_addr;
    logic [SAMPLE_BITS-1:0] mem_rd_data;

    assign mem_wr_en   = load_fire && (32'(in_tbl) < fmwv_pkg::NUM_TABLES)
                         && (32'(in_idx) < TABLE_DEPTH);
    assign mem_wr_addr = AW'(in_tbl) * AW'(TABLE_DEPTH) + AW'(in_idx);
    assign mem_wr_data = SAMPLE_BITS'(in_val);
    assign mem_rd_en   = (r_state == ST_RD);
    assign mem_rd_addr = AW'(sel_tbl) * AW'(TABLE_DEPTH) + AW'(r_idx);

    fmwv_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MEM_DEPTH)
    ) u_wave_ram (
        .i_clk    (i_clk),
        .i_wr_en  (mem_wr_en),
        .i_wr_addr(mem_wr_addr),
        .i_wr_data(mem_wr_data),
        .i_rd_en  (mem_rd_en),
        .i_rd_addr(mem_rd_addr),
        .o_rd_data(mem_rd_data)
    );

    // Bring the modulator sample to Q1.15
    logic signed [31:0] rd_ext;
    logic signed [15:0] ms;
    assign rd_ext = 32'($signed(mem_rd_data));
    assign ms     = 16'((rd_ext <<< SH_UP) >>> SH_DN);

    // Position offsets, octave times running position
    logic [11:0] moff, coff;
    assign moff = 12'(mnote.oct) * 12'(r_mpos);
    assign coff = 12'(cnote.oct) * 12'(r_cpos);

    // Shared multiplier operand select
    logic signed [26:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [44:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_MKM: begin
                mul_a = 27'(fmwv_pkg::conv_rom(mnote.tbl));
                mul_b = 18'(mnote.oct);
            end
            ST_MV: begin
                mul_a = r_prod[26:0];
                mul_b = 18'(r_mph);
            end
            ST_RED1: begin
                mul_a = 27'(r_x);
                mul_b = 18'(fmwv_pkg::recip(sel_tbl));
            end
            ST_RED2: begin
                mul_a = 27'($signed(r_prod[44:24]));
                mul_b = 18'(sel_len);
            end
            ST_RDW: begin
                mul_a = 27'(r_depth);
                mul_b = 18'(ms);
            end
            ST_CA: begin
                mul_a = 27'(fmwv_pkg::conv_rom(cnote.tbl));
                mul_b = 18'(cnote.oct);
            end
            ST_CLO: begin
                mul_a = r_prod[26:0];
                mul_b = {2'b00, r_a[15:0]};
            end
            ST_CHI: begin
                mul_a = r_k;
                mul_b = {r_a[32], r_a[32:16]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 45'(mul_a) * 45'(mul_b);

    // Ceil of the scaled phase plus position offset
    logic [17:0] mx_sum, cx_sum;
    assign mx_sum = r_prod[41:24] + 18'(r_prod[23:0] != '0) + 18'(moff);
    assign cx_sum = r_y[40:23] + 18'(r_y[22:0] != '0) + 18'(coff);

    // Remainder from the approximate quotient, one step of correction
    logic signed [19:0] rem;
    logic [19:0]        rem_fix;
    assign rem = 20'(r_x) - r_prod[19:0];

    always_comb begin
        priority if (rem < 0) begin
            rem_fix = rem + 20'(sel_len);
        end else if (rem >= 20'(sel_len)) begin
            rem_fix = rem - 20'(sel_len);
        end else begin
            rem_fix = rem;
        end
    end

    assign n_idx = fmwv_pkg::IDX_W'(rem_fix);
    assign n_x   = (r_state == ST_CX) ? cx_sum : mx_sum;

    // Advance positions after each tick
    assign n_mpos = (r_mpos == mlen - 9'd1) ? '0 : r_mpos + 9'd1;
    assign n_cpos = (r_cpos == clen - 9'd1) ? '0 : r_cpos + 9'd1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (tick_fire) n_state = ST_MKM;
            ST_MKM:  n_state = ST_MV;
            ST_MV:   n_state = ST_MX;
            ST_MX:   n_state = ST_RED1;
            ST_RED1: n_state = ST_RED2;
            ST_RED2: n_state = ST_RED3;
            ST_RED3: n_state = ST_RD;
            ST_RD:   n_state = ST_RDW;
            ST_RDW: begin
                if (!r_car) begin
                    n_state = ST_CA;
                end else if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CA:   n_state = ST_CLO;
            ST_CLO:  n_state = ST_CHI;
            ST_CHI:  n_state = ST_CY;
            ST_CY:   n_state = ST_CX;
            ST_CX:   n_state = ST_RED1;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_car       <= 1'b0;
            r_reload    <= 1'b0;
            r_mpos      <= '0;
            r_cpos      <= '0;
            r_out_valid <= 1'b0;
            r_mnote     <= '0;
            r_cnote     <= '0;
            r_mph       <= '0;
            r_cph       <= '0;
            r_depth     <= '0;
        end else begin
            r_state <= n_state;

            // Config writes; any known register arms a position reload
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_MOD_NOTE:  r_mnote <= i_cfg_data[5:0];
                    REG_CAR_NOTE:  r_cnote <= i_cfg_data[5:0];
                    REG_MOD_PHASE: r_mph   <= i_cfg_data;
                    REG_CAR_PHASE: r_cph   <= i_cfg_data;
                    REG_DEPTH:     r_depth <= i_cfg_data;
                    default:       ;
                endcase
                if (i_cfg_index <= REG_DEPTH) begin
                    r_reload <= 1'b1;
                end
            end

            // Start of tick: pick modulator pass, apply pending reload
            if (tick_fire) begin
                r_car <= 1'b0;
                if (r_reload) begin
                    r_reload <= 1'b0;
                    r_mpos   <= '0;
                    r_cpos   <= '0;
                end
            end

            // Carrier pass begins after the modulator read
            if (r_state == ST_RDW && !r_car) begin
                r_car <= 1'b1;
            end

            // End of tick: advance positions
            if (out_load) begin
                r_mpos <= n_mpos;
                r_cpos <= n_cpos;
            end

            // Output word handshake
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        unique case (r_state)
            ST_MX, ST_CX: r_x <= n_x;
            ST_RED3:      r_idx <= n_idx;
            ST_CA:        r_a <= r_prod[32:0] + {{2{r_cph[15]}}, r_cph, 15'b0};
            ST_CLO:       r_k <= r_prod[26:0];
            ST_CHI:       r_p <= r_prod[41:0];
            ST_CY:        r_y <= r_prod[43:0] + 44'(r_p[41:16]) + 44'(r_p[15:0] != '0);
            default:      ;
        endcase
        if (out_load) begin
            r_out <= mem_rd_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out);

endmodule
